[rtl/core/wsla_pkg.sv]
// ----------------------------------------------------------------------------
// wsla_pkg
// Shared widths, constants and controller/datapath command types for the
// moving-window mean / deviation level alarm.
// ----------------------------------------------------------------------------
package wsla_pkg;

  // Window geometry and field widths
  localparam int WIN_LEN    = 20;
  localparam int IDX_W      = $clog2(WIN_LEN);
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 10;
  localparam int DEV_W      = 20;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Accumulator and radicand widths
  localparam int S1_W    = SAMPLE_W + IDX_W;
  localparam int S2_W    = 2 * SAMPLE_W + IDX_W;
  localparam int VAR_W   = S2_W + IDX_W;
  localparam int RAD_W   = VAR_W + 8 + (VAR_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W   = (IDX_W > $clog2(SQRT_STEPS)) ? IDX_W : $clog2(SQRT_STEPS);

  // Reciprocal constants: floor(x / WIN_LEN) = (x * M) >> SH, exact for x < 2^(SH-IDX_W)
  localparam int MEAN_SH = S1_W + IDX_W;
  localparam int DEV_SH  = ROOT_W + IDX_W;
  localparam logic [MEAN_SH-1:0] M_MEAN =
    MEAN_SH'(((64'd1 << MEAN_SH) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));
  localparam logic [DEV_SH-1:0] M_DEV =
    DEV_SH'(((64'd1 << DEV_SH) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));

  // Threshold arithmetic
  localparam int GPROD_W = SAMPLE_W + GAIN_W;
  localparam int THR_W   = GPROD_W - 4 + 1;

  // Register reset values
  localparam logic [LEVEL_W-1:0] READY_LEVEL_RST = LEVEL_W'(400);
  localparam logic [GAIN_W-1:0]  HIGH_GAIN_RST   = GAIN_W'(307);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READY_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN   = 1'b1;

  typedef struct packed {
    logic             load;
    logic             check;
    logic             walk;
    logic [CNT_W-1:0] cnt;
    logic             prep1;
    logic             prep2;
    logic             sqrt_step;
    logic             fin1;
    logic             fin2;
  } dp_cmd_t;

  typedef struct packed {
    logic win_ready;
  } dp_sts_t;

endpackage

[rtl/core/wsla_if.sv]
// ----------------------------------------------------------------------------
// wsla_if
// Valid/ready stream interfaces for the sample input and the result output.
// ----------------------------------------------------------------------------
interface wsla_in_if
  import wsla_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wsla_out_if
  import wsla_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                ready_res;
  logic                alarm;
  logic [SAMPLE_W-1:0] window_mean;
  logic [DEV_W-1:0]    deviation_q4;

  modport source (output valid, output ready_res, output alarm, output window_mean,
                  output deviation_q4, input ready);
  modport sink   (input valid, input ready_res, input alarm, input window_mean,
                  input deviation_q4, output ready);
endinterface

[rtl/core/wsla_ctrl.sv]
// ----------------------------------------------------------------------------
// wsla_ctrl
// Sequencer: accepts one sample, steps the datapath through write, window
// walk and, for an armed window, variance prep, square root and final
// scaling, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wsla_ctrl
  import wsla_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_DRAIN = 4'd3;
  localparam logic [3:0] ST_PREP1 = 4'd4;
  localparam logic [3:0] ST_PREP2 = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_FIN1  = 4'd7;
  localparam logic [3:0] ST_FIN2  = 4'd8;

  localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(WIN_LEN - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fin_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign fin_fire  = (state_r == ST_FIN2) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_WALK;
        cnt_nxt   = '0;
      end
      ST_WALK: begin
        // drop straight to the result when the window is not armed
        if (cnt_r == '0 && !sts.win_ready) begin
          state_nxt = ST_FIN2;
        end else if (cnt_r == WALK_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: state_nxt = ST_PREP1;
      ST_PREP1: state_nxt = ST_PREP2;
      ST_PREP2: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_FIN1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.cnt       = cnt_r;
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.check     = (state_r == ST_CHECK);
    cmd.walk      = (state_r == ST_WALK);
    cmd.prep1     = (state_r == ST_PREP1);
    cmd.prep2     = (state_r == ST_PREP2);
    cmd.sqrt_step = (state_r == ST_SQRT);
    cmd.fin1      = (state_r == ST_FIN1);
    cmd.fin2      = fin_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/wsla_dp.sv]
// ----------------------------------------------------------------------------
// wsla_dp
// Datapath: sample ring, sum / sum-of-squares accumulators, variance prep,
// two-bits-per-step square root, reciprocal scaling and the result register.
// ----------------------------------------------------------------------------
module wsla_dp
  import wsla_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [LEVEL_W-1:0]  ready_level,
  input  logic [GAIN_W-1:0]   high_gain,
  output logic                res_ready,
  output logic                res_alarm,
  output logic [SAMPLE_W-1:0] res_mean,
  output logic [DEV_W-1:0]    res_dev
);

  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(WIN_LEN - 1);

  logic [SAMPLE_W-1:0]        store_r [WIN_LEN];
  logic [IDX_W-1:0]           slot_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic                       win_ready_r;
  logic                       pv_r;
  logic [SAMPLE_W-1:0]        x_r;
  logic [2*SAMPLE_W-1:0]      sq_r;
  logic [S1_W-1:0]            s1_r;
  logic [S2_W-1:0]            s2_r;
  logic [VAR_W-1:0]           nsq_r, s1sq_r;
  logic [S1_W+MEAN_SH-1:0]    mprod_r;
  logic [SAMPLE_W-1:0]        mean_r;
  logic [RAD_W-1:0]           rem_r, root_r, bit_r;
  logic [ROOT_W+DEV_SH-1:0]   dprod_r;
  logic [GPROD_W-1:0]         gprod_r;
  logic                       res_ready_r, res_alarm_r;
  logic [SAMPLE_W-1:0]        res_mean_r;
  logic [DEV_W-1:0]           res_dev_r;

  logic [SAMPLE_W-1:0]        rd_x;
  logic [VAR_W-1:0]           s1_ext, s2_ext, var_diff;
  logic [S1_W+MEAN_SH-1:0]    s1_mx, m_mean_x;
  logic [RAD_W:0]             trial;
  logic [ROOT_W+DEV_SH-1:0]   root_dx, m_dev_x;
  logic [GPROD_W-1:0]         mean_gx, gain_gx;
  logic [DEV_W-1:0]           dev_val;
  logic [THR_W-1:0]           thr, smp16;

  assign rd_x     = store_r[cmd.cnt[IDX_W-1:0]];
  assign s1_ext   = VAR_W'(s1_r);
  assign s2_ext   = VAR_W'(s2_r);
  assign var_diff = nsq_r - s1sq_r;
  assign s1_mx    = (S1_W+MEAN_SH)'(s1_r);
  assign m_mean_x = (S1_W+MEAN_SH)'(M_MEAN);
  assign trial    = {1'b0, root_r} + {1'b0, bit_r};
  assign root_dx  = (ROOT_W+DEV_SH)'(root_r[ROOT_W-1:0]);
  assign m_dev_x  = (ROOT_W+DEV_SH)'(M_DEV);
  assign mean_gx  = GPROD_W'(mean_r);
  assign gain_gx  = GPROD_W'(high_gain);
  assign dev_val  = dprod_r[DEV_SH +: DEV_W];
  assign thr      = THR_W'(dev_val) + THR_W'(gprod_r[GPROD_W-1:4]);
  assign smp16    = THR_W'({sample_r, 4'b0000});

  assign sts.win_ready = win_ready_r;

  // ring store and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        store_r[k] <= '0;
      end
      slot_r <= '0;
    end else if (cmd.load) begin
      store_r[slot_r] <= in_sample;
      slot_r          <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.check) begin
      win_ready_r <= (store_r[WIN_LEN-1] >= ready_level);
      s1_r        <= '0;
      s2_r        <= '0;
    end else if (pv_r) begin
      s1_r <= s1_r + S1_W'(x_r);
      s2_r <= s2_r + S2_W'(sq_r);
    end
    if (cmd.walk) begin
      x_r  <= rd_x;
      sq_r <= rd_x * rd_x;
    end
    if (cmd.prep1) begin
      nsq_r   <= s2_ext * VAR_W'(WIN_LEN);
      s1sq_r  <= s1_ext * s1_ext;
      mprod_r <= s1_mx * m_mean_x;
    end
    if (cmd.prep2) begin
      rem_r  <= RAD_W'({var_diff, 8'h00});
      root_r <= '0;
      bit_r  <= RAD_W'(1) << (RAD_W - 2);
      mean_r <= mprod_r[MEAN_SH +: SAMPLE_W];
    end else if (cmd.sqrt_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - trial[RAD_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.fin1) begin
      dprod_r <= root_dx * m_dev_x;
      gprod_r <= mean_gx * gain_gx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin2) begin
      res_ready_r <= win_ready_r;
      if (win_ready_r) begin
        res_alarm_r <= (smp16 > thr);
        res_mean_r  <= mean_r;
        res_dev_r   <= dev_val;
      end else begin
        res_alarm_r <= 1'b0;
        res_mean_r  <= '0;
        res_dev_r   <= '0;
      end
    end
  end

  assign res_ready = res_ready_r;
  assign res_alarm = res_alarm_r;
  assign res_mean  = res_mean_r;
  assign res_dev   = res_dev_r;

endmodule

[rtl/core/window_stddev_level_alarm.sv]
// ----------------------------------------------------------------------------
// window_stddev_level_alarm
// Moving-window mean and standard deviation of gas readings with a level
// alarm; one result per accepted sample.
// ----------------------------------------------------------------------------
// Each sample transfer writes the reading into a 20-entry ring (cleared by
// reset) and produces exactly one result transfer. The window counts as ready
// once the last ring slot holds at least ready_level; only then are the
// truncated mean, the floored population deviation in Q.4 and the alarm
// (sample*16 > deviation_q4 + (mean*high_gain)>>4) reported, otherwise those
// fields are zero. An armed sample goes from its transfer to its result
// through the write, the sum / sum-of-squares walk over the ring entries
// through one squaring multiplier, the variance prep, the two-bits-per-step
// square root and the reciprocal scaling; an unarmed sample skips straight
// from the walk to the result. The input takes the next sample as soon as
// the result is parked in the output register, so a slow consumer costs at
// most one item of overlap. Configuration writes (index 0 ready_level,
// index 1 high_gain) are registered and belong between items.
// ----------------------------------------------------------------------------
module window_stddev_level_alarm
  import wsla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wsla_in_if.sink               in_ch,
  wsla_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LEVEL_W-1:0] ready_level_r;
  logic [GAIN_W-1:0]  high_gain_r;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  // Configuration registers: take the low bits of the write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_level_r <= READY_LEVEL_RST;
      high_gain_r   <= HIGH_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_READY_LEVEL: ready_level_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_HIGH_GAIN:   high_gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns the handshakes and the step counter
  wsla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: ring, accumulators, root and the held result
  wsla_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   (in_ch.sample),
    .ready_level (ready_level_r),
    .high_gain   (high_gain_r),
    .res_ready   (out_ch.ready_res),
    .res_alarm   (out_ch.alarm),
    .res_mean    (out_ch.window_mean),
    .res_dev     (out_ch.deviation_q4)
  );

endmodule
